/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of the block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MI3_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mi3_pkg.sv */
// Shared types, constants and the rounding helper of the 3x3 matrix inverse.
// Depends on nothing; every other file of the block but assert_macros.svh refers to it by scoped names.
package mi3_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int ELEM_W  = 32;
   localparam int COF_W   = 64;
   localparam int PL_W    = 65;
   localparam int TERM_W  = 96;
   localparam int DET_W   = 97;
   localparam int DABS_W  = 96;
   localparam int THR_W   = 31;
   localparam int QUOT_W  = 32;
   localparam int REM_W   = 97;
   localparam int MAG_W   = 97;
   localparam int IDX_W   = 4;
   localparam int N_ELEM  = 9;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(0);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(N_ELEM - 1);
   localparam logic [MAG_W-1:0] LIM_POS   = MAG_W'(32'h7FFF_FFFF);
   localparam logic [MAG_W-1:0] LIM_NEG   = MAG_W'(32'h8000_0000);

   // Cofactor k of the adjugate is m[A]*m[B] - m[C]*m[D], row-major indexes.
   localparam int COF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_C [N_ELEM] = '{7, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_D [N_ELEM] = '{5, 8, 4, 8, 6, 5, 6, 7, 3};
   // Cofactors that pair with row 0 in the determinant expansion.
   localparam int DET_COF [3] = '{0, 3, 6};

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic signed [PL_W-1:0]   pl_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [DET_W-1:0]  det_type;

   // One classified matrix, handed from the front end to the back end.
   typedef struct packed {
      cof_type [N_ELEM-1:0] cof;
      logic [DABS_W-1:0]    dabs;
      logic                 dneg;
      elem_type             det_value;
      logic                 det_sat;
      logic                 sing;
   } job_type;

   // Per-quotient side information that rides along the divider.
   typedef struct packed {
      logic             neg;
      logic [IDX_W-1:0] idx;
      logic             sing;
      elem_type         det_value;
      logic             det_sat;
   } div_meta_type;

   typedef struct packed {
      logic [COF_W-1:0]  mag;
      logic [DABS_W-1:0] d;
      div_meta_type      meta;
   } div_op_type;

   typedef struct packed {
      logic [REM_W-1:0]  r;
      logic [QUOT_W-1:0] lo;
      logic [QUOT_W-1:0] q;
      logic [DABS_W-1:0] d;
      logic              ovf;
      div_meta_type      meta;
   } div_stage_type;

   typedef struct packed {
      elem_type [N_ELEM-1:0] inv;
      elem_type              det_value;
      logic                  singular;
      logic                  saturated;
   } result_type;

   typedef struct packed {
      elem_type value;
      logic     sat;
   } sat_type;

   // Applies the sign to a rounded magnitude and clips it to the 32-bit range.
   function automatic sat_type round_sat(input logic neg, input logic [MAG_W-1:0] mag);
      logic [MAG_W-1:0] limit;
      logic [MAG_W-1:0] clip;
      sat_type          res;
      limit     = neg ? LIM_NEG : LIM_POS;
      res.sat   = mag > limit;
      clip      = res.sat ? limit : mag;
      res.value = neg ? (~clip[ELEM_W-1:0] + 1'b1) : clip[ELEM_W-1:0];
      return res;
   endfunction

endpackage

/* rtl/core/mi3_if.sv */
// Valid/ready channel interfaces for matrices in and inverses out.
// Depends on mi3_pkg for the element type.
interface mi3_req_if;
   logic               valid;
   logic               ready;
   mi3_pkg::elem_type  m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22;

   modport source (output valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                   input ready);
   modport sink   (input valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                   output ready);
endinterface

interface mi3_rsp_if;
   logic               valid;
   logic               ready;
   mi3_pkg::elem_type  inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22;
   mi3_pkg::elem_type  det_value;
   logic               singular;
   logic               saturated;

   modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20,
                   inv_21, inv_22, det_value, singular, saturated, input ready);
   modport sink   (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20,
                   inv_21, inv_22, det_value, singular, saturated, output ready);
endinterface

/* rtl/core/mi3_front.sv */
// Front end: cofactors, determinant, rounding of det_value and singular test.
// Depends on mi3_pkg; six pipeline stages that all advance together.
module mi3_front #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  mi3_pkg::elem_type [mi3_pkg::N_ELEM-1:0] in_mat,
   input  logic [mi3_pkg::THR_W-1:0]          thr,
   output logic                               out_valid,
   input  logic                               out_ready,
   output mi3_pkg::job_type                   out_job
);
   localparam int SH = 2 * FRAC_BITS;
   localparam int NE = mi3_pkg::N_ELEM;

   logic adv;
   logic [5:0] v_ff, v_in;

   mi3_pkg::cof_type  p1_ff [NE], p1_in [NE];
   mi3_pkg::cof_type  p2_ff [NE], p2_in [NE];
   mi3_pkg::elem_type mr1_ff [3], mr2_ff [3];
   mi3_pkg::cof_type  n2_ff [NE], n2_in [NE];
   mi3_pkg::cof_type  n3_ff [NE], n4_ff [NE], n5_ff [NE], n6_ff [NE];
   mi3_pkg::cof_type  ph_ff [3], ph_in [3];
   mi3_pkg::pl_type   pl_ff [3], pl_in [3];
   mi3_pkg::term_type t_ff [3], t_in [3];
   mi3_pkg::det_type  det_ff, det_in;
   logic [mi3_pkg::DABS_W-1:0] dabs_ff, dabs_in;
   logic dneg_ff, dneg_in;

   logic [mi3_pkg::DABS_W-1:0] dq;
   logic [mi3_pkg::MAG_W-1:0]  dmag;
   mi3_pkg::sat_type           dval;

   // The whole pipe holds when its last stage has a job the queue cannot take.
   assign adv      = !(v_ff[5] && !out_ready);
   assign in_ready = adv;
   assign v_in     = {v_ff[4:0], in_valid};

   // Stage 1: the eighteen element products; stage 2: cofactor differences.
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         p1_in[k] = mi3_pkg::cof_type'(in_mat[mi3_pkg::COF_A[k]])
                  * mi3_pkg::cof_type'(in_mat[mi3_pkg::COF_B[k]]);
         p2_in[k] = mi3_pkg::cof_type'(in_mat[mi3_pkg::COF_C[k]])
                  * mi3_pkg::cof_type'(in_mat[mi3_pkg::COF_D[k]]);
         n2_in[k] = p1_ff[k] - p2_ff[k];
      end
   end

   // Stage 3: row 0 times upper and lower halves of its cofactors.
   // Stage 4: halves joined into one term; stage 5: the three terms summed.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ph_in[k] = mi3_pkg::cof_type'(mr2_ff[k])
                  * mi3_pkg::cof_type'($signed(n2_ff[mi3_pkg::DET_COF[k]][63:32]));
         pl_in[k] = mi3_pkg::pl_type'(mr2_ff[k])
                  * mi3_pkg::pl_type'($signed({1'b0, n2_ff[mi3_pkg::DET_COF[k]][31:0]}));
         t_in[k]  = $signed({ph_ff[k], 32'b0}) + mi3_pkg::term_type'(pl_ff[k]);
      end
      det_in = mi3_pkg::det_type'(t_ff[0]) + mi3_pkg::det_type'(t_ff[1])
             + mi3_pkg::det_type'(t_ff[2]);
   end

   // Stage 6: sign and magnitude of the determinant.
   assign dneg_in = det_ff[mi3_pkg::DET_W-1];
   assign dabs_in = dneg_in ? mi3_pkg::DABS_W'(-det_ff) : mi3_pkg::DABS_W'(det_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         mr1_ff  <= '{in_mat[0], in_mat[1], in_mat[2]};
         mr2_ff  <= mr1_ff;
         n2_ff   <= n2_in;
         n3_ff   <= n2_ff;
         n4_ff   <= n3_ff;
         n5_ff   <= n4_ff;
         n6_ff   <= n5_ff;
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         t_ff    <= t_in;
         det_ff  <= det_in;
         dabs_ff <= dabs_in;
         dneg_ff <= dneg_in;
      end
   end

   // Determinant rounded to FRAC_BITS fraction bits, and the singular test.
   always_comb begin
      dq   = dabs_ff >> SH;
      dmag = {1'b0, dq} + mi3_pkg::MAG_W'(dabs_ff[SH-1]);
      dval = mi3_pkg::round_sat(dneg_ff, dmag);
      for (int k = 0; k < NE; k++) begin
         out_job.cof[k] = n6_ff[k];
      end
      out_job.dabs      = dabs_ff;
      out_job.dneg      = dneg_ff;
      out_job.det_value = dval.value;
      out_job.det_sat   = dval.sat;
      out_job.sing      = dabs_ff <= (mi3_pkg::DABS_W'(thr) << SH);
   end

   assign out_valid = v_ff[5];

endmodule

/* rtl/core/mi3_queue.sv */
// Small FIFO of classified matrices between the front end and the back end.
// Depends on mi3_pkg for the job type.
module mi3_queue #(
   parameter int DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mi3_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mi3_pkg::job_type pop_job
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   mi3_pkg::job_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign push_ready = cnt_ff != CNT_FULL;
   assign pop_valid  = cnt_ff != '0;
   assign pop_job    = store_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer wrap and occupancy.
   always_comb begin
      wr_in  = do_push ? ((wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_job;
      end
   end

endmodule

/* rtl/core/mi3_divider.sv */
// Pipelined restoring divider: one quotient enters and one leaves per unstalled cycle.
// Depends on mi3_pkg; an entry stage, an overflow precheck and 32 quotient-bit stages.
module mi3_divider #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mi3_pkg::div_op_type   in_op,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mi3_pkg::div_stage_type out_stage
);
   localparam int SH    = 2 * FRAC_BITS;
   localparam int NUM_W = mi3_pkg::COF_W + SH;
   localparam int QW    = mi3_pkg::QUOT_W;
   localparam int RW    = mi3_pkg::REM_W;
   localparam int NSTEP = QW;

   logic en;
   logic op_v_ff;
   mi3_pkg::div_op_type    op_ff;
   logic [NUM_W-1:0]       num_w;
   logic                   sv_ff [NSTEP+1];
   mi3_pkg::div_stage_type st_ff [NSTEP+1];
   mi3_pkg::div_stage_type st_in [NSTEP+1];

   assign en       = !(sv_ff[NSTEP] && !out_ready);
   assign in_ready = en;

   // Precheck: a quotient of 2^32 or more always clips.
   always_comb begin
      num_w          = {op_ff.mag, {SH{1'b0}}};
      st_in[0].r     = RW'(num_w[NUM_W-1:QW]);
      st_in[0].lo    = num_w[QW-1:0];
      st_in[0].q     = '0;
      st_in[0].d     = op_ff.d;
      st_in[0].ovf   = RW'(num_w[NUM_W-1:QW]) >= {1'b0, op_ff.d};
      st_in[0].meta  = op_ff.meta;
   end

   // One quotient bit per stage.
   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      logic [RW-1:0] rs;
      logic          ge;
      always_comb begin
         rs = {st_ff[k].r[RW-2:0], st_ff[k].lo[QW-1]};
         ge = rs >= {1'b0, st_ff[k].d};
         st_in[k+1]      = st_ff[k];
         st_in[k+1].r    = ge ? rs - {1'b0, st_ff[k].d} : rs;
         st_in[k+1].lo   = {st_ff[k].lo[QW-2:0], 1'b0};
         st_in[k+1].q    = {st_ff[k].q[QW-2:0], ge};
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_v_ff <= 1'b0;
         for (int k = 0; k <= NSTEP; k++) begin
            sv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         op_v_ff  <= in_valid;
         sv_ff[0] <= op_v_ff;
         for (int k = 0; k < NSTEP; k++) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (en) begin
         op_ff <= in_op;
         st_ff <= st_in;
      end
   end

   assign out_valid = sv_ff[NSTEP];
   assign out_stage = st_ff[NSTEP];

endmodule

/* rtl/core/mi3_back.sv */
// Back end: issues nine quotients per matrix into the divider and collects the
// rounded results into the output register. Depends on mi3_pkg and mi3_divider.
module mi3_back #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  mi3_pkg::job_type    job,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mi3_pkg::result_type rsp_result
);
   localparam int IW = mi3_pkg::IDX_W;

   logic [IW-1:0] idx_ff, idx_in;
   logic          div_ready, issue, issue_last;
   mi3_pkg::cof_type       cof_sel;
   mi3_pkg::div_op_type    op;
   logic                   dv_valid, dv_ready, dv_last, dv_take;
   mi3_pkg::div_stage_type dv;
   logic                   up;
   logic [mi3_pkg::MAG_W-1:0] mag;
   mi3_pkg::sat_type       rnd;
   mi3_pkg::elem_type      val;
   logic                   sat;

   mi3_pkg::elem_type acc_ff [mi3_pkg::N_ELEM];
   logic              sacc_ff, sacc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mi3_pkg::result_type rsp_ff;

   // Dispatcher: one cofactor per divider-ready cycle, popping the job with the last.
   assign issue      = job_valid && div_ready;
   assign issue_last = idx_ff == mi3_pkg::LAST_IDX;
   assign job_ready  = issue && issue_last;
   assign idx_in     = issue ? (issue_last ? mi3_pkg::FIRST_IDX : idx_ff + 1'b1) : idx_ff;

   always_comb begin
      cof_sel            = job.cof[idx_ff];
      op.mag             = cof_sel[mi3_pkg::COF_W-1] ? mi3_pkg::COF_W'(-cof_sel)
                                                     : mi3_pkg::COF_W'(cof_sel);
      op.d               = job.dabs;
      op.meta.neg        = cof_sel[mi3_pkg::COF_W-1] ^ job.dneg;
      op.meta.idx        = idx_ff;
      op.meta.sing       = job.sing;
      op.meta.det_value  = job.det_value;
      op.meta.det_sat    = job.det_sat;
   end

   mi3_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_ready  (div_ready),
      .in_op     (op),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_stage (dv)
   );

   // Round half away from zero, clip, and zero the element of a singular matrix.
   always_comb begin
      up  = {dv.r, 1'b0} >= {2'b0, dv.d};
      mag = dv.ovf ? '1 : (mi3_pkg::MAG_W'(dv.q) + mi3_pkg::MAG_W'(up));
      rnd = mi3_pkg::round_sat(dv.meta.neg, mag);
      val = dv.meta.sing ? '0 : rnd.value;
      sat = dv.meta.sing ? 1'b0 : rnd.sat;
   end

   // Collector: the last element waits while the output register is still full.
   assign dv_last  = dv.meta.idx == mi3_pkg::LAST_IDX;
   assign dv_ready = !(dv_last && rsp_valid_ff && !rsp_ready);
   assign dv_take  = dv_valid && dv_ready;
   assign sacc_in  = ((dv.meta.idx == mi3_pkg::FIRST_IDX) ? 1'b0 : sacc_ff) | sat;
   assign rsp_valid_in = (dv_take && dv_last) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= mi3_pkg::FIRST_IDX;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_take) begin
         acc_ff[dv.meta.idx] <= val;
         sacc_ff             <= sacc_in;
      end
      if (dv_take && dv_last) begin
         for (int k = 0; k < mi3_pkg::N_ELEM - 1; k++) begin
            rsp_ff.inv[k] <= acc_ff[k];
         end
         rsp_ff.inv[mi3_pkg::N_ELEM-1] <= val;
         rsp_ff.det_value <= dv.meta.det_value;
         rsp_ff.singular  <= dv.meta.sing;
         rsp_ff.saturated <= dv.meta.det_sat | sacc_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

/* rtl/core/matrix3x3_inverse.sv */
// Top level of the 3x3 matrix inverse by the adjugate method.
// Depends on mi3_pkg, mi3_if, mi3_front, mi3_queue and mi3_back.
//
//   Channel   Direction  Handshake          Contents
//   req_chan  in         valid/ready        nine Q16.16 matrix elements
//   rsp_chan  out        valid/ready        nine inverse elements, det, flags
//   csr_*     in         write enable only  singular_threshold (31 bits)
//
// A matrix is taken every cycle until the queue fills; sustained throughput is
// set by the single divider taking one quotient a cycle when not stalled, nine per matrix.
// Path from the accepting edge: 6 front stages, the queue, 34 divider stages into which
// the nine quotients are issued one after another, and the output register.
// Reset is synchronous and sets the threshold to 7.
// The output register holds a result until taken; the divider and front stall behind it.
module matrix3x3_inverse #(
   parameter int FRAC_BITS   = mi3_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [mi3_pkg::THR_W-1:0] csr_write_data,
   mi3_req_if.sink                   req_chan,
   mi3_rsp_if.source                 rsp_chan
);
   logic [mi3_pkg::THR_W-1:0] thr_ff;
   mi3_pkg::elem_type [mi3_pkg::N_ELEM-1:0] mat;
   logic                f_valid, f_ready, q_valid, q_ready;
   mi3_pkg::job_type    f_job, q_job;
   mi3_pkg::result_type res;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mi3_pkg::THR_RESET;
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   assign mat = {req_chan.m_22, req_chan.m_21, req_chan.m_20,
                 req_chan.m_12, req_chan.m_11, req_chan.m_10,
                 req_chan.m_02, req_chan.m_01, req_chan.m_00};

   mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_mat    (mat),
      .thr       (thr_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_job   (f_job)
   );

   mi3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_job    (q_job)
   );

   mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job_ready  (q_ready),
      .job        (q_job),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_result (res)
   );

   assign rsp_chan.inv_00    = res.inv[0];
   assign rsp_chan.inv_01    = res.inv[1];
   assign rsp_chan.inv_02    = res.inv[2];
   assign rsp_chan.inv_10    = res.inv[3];
   assign rsp_chan.inv_11    = res.inv[4];
   assign rsp_chan.inv_12    = res.inv[5];
   assign rsp_chan.inv_20    = res.inv[6];
   assign rsp_chan.inv_21    = res.inv[7];
   assign rsp_chan.inv_22    = res.inv[8];
   assign rsp_chan.det_value = res.det_value;
   assign rsp_chan.singular  = res.singular;
   assign rsp_chan.saturated = res.saturated;

endmodule

/* rtl/core/mi3_checker.sv */
// Port-level checker of the matrix inverse, bound to the top level.
// Depends on assert_macros.svh and mi3_pkg.
`include "assert_macros.svh"

module mi3_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [9*32-1:0]   rsp_inv,
   input mi3_pkg::elem_type rsp_det,
   input logic              rsp_singular,
   input logic              rsp_saturated
);
   logic [9*32+32+1:0] rsp_word;

   assign rsp_word = {rsp_inv, rsp_det, rsp_singular, rsp_saturated};

   // A stalled transaction stays offered and unchanged.
   `MI3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `MI3_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word), "rsp changed")
   // A singular matrix has an all-zero inverse.
   `MI3_ASSERT_SAME(a_sing_zero, clock, reset, rsp_valid && rsp_singular, rsp_inv == '0, "nonzero inverse")
   // Nothing is offered right after reset.
   `MI3_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_inv       ({rsp_chan.inv_00, rsp_chan.inv_01, rsp_chan.inv_02,
                    rsp_chan.inv_10, rsp_chan.inv_11, rsp_chan.inv_12,
                    rsp_chan.inv_20, rsp_chan.inv_21, rsp_chan.inv_22}),
   .rsp_det       (rsp_chan.det_value),
   .rsp_singular  (rsp_chan.singular),
   .rsp_saturated (rsp_chan.saturated)
);

/* verif/matrix3x3_inverse_tb.sv */
// Self-checking testbench for the 3x3 matrix inverse by the adjugate method.
// Depends on mi3_pkg, the mi3_req_if/mi3_rsp_if interfaces and matrix3x3_inverse.
module matrix3x3_inverse_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef mi3_pkg::elem_type elem_type;
   typedef logic signed [127:0] wide_type;
   typedef logic [mi3_pkg::THR_W-1:0] thr_type;

   // One inverse transaction as it is expected on the result channel.
   typedef struct {
      elem_type inv [9];
      elem_type det;
      logic     sing;
      logic     sat;
   } inverse_type;

   // One row of the directed table; the expectation is used only when fixed is set.
   typedef struct {
      elem_type    m [9];
      logic        fixed;
      inverse_type want;
   } matrix_row_type;

   localparam elem_type ONE   = 32'sh0001_0000;
   localparam elem_type MAXV  = 32'sh7FFF_FFFF;
   localparam elem_type MINV  = 32'sh8000_0000;
   localparam int       DRAIN = 80;

   logic    clock;
   logic    reset;
   logic    csr_write_en;
   thr_type csr_write_data;

   mi3_req_if req_bus ();
   mi3_rsp_if rsp_bus ();

   matrix3x3_inverse DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus)
   );

   inverse_type pending_inverses [$];
   thr_type     threshold_now;
   int          error_count;
   logic        cur_fixed;
   inverse_type cur_want;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Signs and clips a rounded magnitude to the 32-bit range.
   function automatic elem_type clip_signed(input logic neg, input logic [127:0] mag,
                                            inout logic sat);
      logic [127:0] limit;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (mag > limit) begin
         mag = limit;
         sat = 1'b1;
      end
      return neg ? elem_type'(-mag[31:0]) : elem_type'(mag[31:0]);
   endfunction

   function automatic wide_type minor2(input elem_type a, input elem_type b,
                                       input elem_type c, input elem_type d);
      wide_type wa, wb, wc, wd;
      wa = a; wb = b; wc = c; wd = d;
      return wa * wb - wc * wd;
   endfunction

   // Computes the expected inverse, determinant and flags of one matrix.
   function automatic inverse_type predict_inverse(input elem_type m [9], input thr_type thr);
      inverse_type  res;
      wide_type     cof [9];
      wide_type     det, w0, w1, w2;
      logic [127:0] dabs, num, quo, rmd, cmag, limit_thr;
      logic         dneg, sat;
      cof[0] = minor2(m[4], m[8], m[7], m[5]);
      cof[1] = minor2(m[2], m[7], m[1], m[8]);
      cof[2] = minor2(m[1], m[5], m[2], m[4]);
      cof[3] = minor2(m[5], m[6], m[3], m[8]);
      cof[4] = minor2(m[0], m[8], m[2], m[6]);
      cof[5] = minor2(m[2], m[3], m[0], m[5]);
      cof[6] = minor2(m[3], m[7], m[4], m[6]);
      cof[7] = minor2(m[1], m[6], m[0], m[7]);
      cof[8] = minor2(m[0], m[4], m[1], m[3]);
      w0 = m[0]; w1 = m[1]; w2 = m[2];
      det  = w0 * cof[0] + w1 * cof[3] + w2 * cof[6];
      dneg = det[127];
      dabs = dneg ? -det : det;
      sat  = 1'b0;
      res.det = clip_signed(dneg, (dabs >> 32) + dabs[31], sat);
      limit_thr = {97'd0, thr} << 32;
      res.sing  = dabs <= limit_thr;
      for (int k = 0; k < 9; k++) begin
         if (res.sing) begin
            res.inv[k] = '0;
         end else begin
            cmag = cof[k][127] ? -cof[k] : cof[k];
            num  = cmag << 32;
            quo  = num / dabs;
            rmd  = num % dabs;
            res.inv[k] = clip_signed(cof[k][127] ^ dneg, quo + ((rmd << 1) >= dabs), sat);
         end
      end
      res.sat = sat;
      return res;
   endfunction

   // Draws one element from a mix of full-range, extreme, unit-scale, moderate and tiny values.
   function automatic elem_type draw_elem();
      elem_type v;
      case ($urandom_range(0, 6))
         0: v = $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: v = MAXV;
               1: v = MINV;
               2: v = '0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         2, 3: v = elem_type'($urandom_range(0, 8 * 65536)) - elem_type'(4 * 65536);
         4: v = elem_type'($urandom_range(0, 600)) - 300;
         default: v = elem_type'($urandom_range(0, 1 << 21)) - elem_type'(1 << 20);
      endcase
      return v;
   endfunction

   // Builds a random matrix; some are made singular or near the threshold on purpose.
   function automatic void draw_matrix(output elem_type m [9]);
      for (int k = 0; k < 9; k++) m[k] = draw_elem();
      case ($urandom_range(0, 9))
         0: for (int k = 0; k < 3; k++) m[6 + k] = m[k];
         1: for (int k = 0; k < 3; k++) m[3 + k] = -m[k];
         2: begin
            for (int k = 0; k < 9; k++) m[k] = '0;
            m[0] = ONE; m[4] = ONE;
            m[8] = elem_type'($urandom_range(0, 20)) - 10;
         end
         default: ;
      endcase
   endfunction

   // Writes the threshold register; only called while the block is idle.
   task automatic write_threshold(input thr_type value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      threshold_now   = value;
   endtask

   // Waits until every expected transaction has arrived, then lets the pipeline drain.
   task automatic wait_idle();
      while (pending_inverses.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   // Presents one matrix after a random gap and holds it until accepted.
   task automatic send_matrix(input elem_type m [9], input logic fixed, input inverse_type want);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.m_00 <= m[0]; req_bus.m_01 <= m[1]; req_bus.m_02 <= m[2];
      req_bus.m_10 <= m[3]; req_bus.m_11 <= m[4]; req_bus.m_12 <= m[5];
      req_bus.m_20 <= m[6]; req_bus.m_21 <= m[7]; req_bus.m_22 <= m[8];
      cur_fixed      <= fixed;
      cur_want       <= want;
      req_bus.valid  <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Sends a run of random matrices and then drops valid.
   task automatic send_random(input int count);
      elem_type    m [9];
      inverse_type none;
      none = '{default: 0, inv: '{default: 0}};
      for (int n = 0; n < count; n++) begin
         draw_matrix(m);
         send_matrix(m, 1'b0, none);
      end
      req_bus.valid <= 1'b0;
   endtask

   // Result channel consumer: random stall before each transaction.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // Records accepted matrices and checks accepted inverses against the oldest one.
   always @(posedge clock) begin
      elem_type    m [9];
      elem_type    got [9];
      inverse_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         m = '{req_bus.m_00, req_bus.m_01, req_bus.m_02, req_bus.m_10, req_bus.m_11,
               req_bus.m_12, req_bus.m_20, req_bus.m_21, req_bus.m_22};
         pending_inverses.push_back(cur_fixed ? cur_want : predict_inverse(m, threshold_now));
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.inv_00, rsp_bus.inv_01, rsp_bus.inv_02, rsp_bus.inv_10,
                 rsp_bus.inv_11, rsp_bus.inv_12, rsp_bus.inv_20, rsp_bus.inv_21,
                 rsp_bus.inv_22};
         if (pending_inverses.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = pending_inverses.pop_front();
            for (int k = 0; k < 9; k++)
               if (got[k] !== want.inv[k])
                  report_mismatch($sformatf("inv_%0d%0d", k / 3, k % 3), got[k], want.inv[k]);
            if (rsp_bus.det_value !== want.det)
               report_mismatch("det_value", rsp_bus.det_value, want.det);
            if (rsp_bus.singular !== want.sing)
               report_mismatch("singular", rsp_bus.singular, want.sing);
            if (rsp_bus.saturated !== want.sat)
               report_mismatch("saturated", rsp_bus.saturated, want.sat);
         end
      end
   end

   // Main sequence: reset, directed table, then random phases over several thresholds.
   initial begin
      matrix_row_type table_rows [$];
      inverse_type    zero_inv;
      elem_type       z;
      z = '0;
      zero_inv = '{inv: '{default: 0}, det: 0, sing: 1, sat: 0};
      error_count    = 0;
      threshold_now  = mi3_pkg::THR_RESET;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_bus.valid  = 1'b0;
      {req_bus.m_00, req_bus.m_01, req_bus.m_02, req_bus.m_10, req_bus.m_11,
       req_bus.m_12, req_bus.m_20, req_bus.m_21, req_bus.m_22} = '0;
      cur_fixed = 1'b0;
      cur_want  = zero_inv;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero matrix, equal rows at both extremes, identity, doubled identity.
      table_rows.push_back('{m: '{z, z, z, z, z, z, z, z, z}, fixed: 1, want: zero_inv});
      table_rows.push_back('{m: '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV},
                             fixed: 1, want: zero_inv});
      table_rows.push_back('{m: '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV},
                             fixed: 1, want: zero_inv});
      table_rows.push_back('{m: '{ONE, z, z, z, ONE, z, z, z, ONE}, fixed: 1,
                             want: '{inv: '{ONE, z, z, z, ONE, z, z, z, ONE},
                                     det: ONE, sing: 0, sat: 0}});
      table_rows.push_back('{m: '{2 * ONE, z, z, z, 2 * ONE, z, z, z, 2 * ONE}, fixed: 1,
                             want: '{inv: '{ONE / 2, z, z, z, ONE / 2, z, z, z, ONE / 2},
                                     det: 8 * ONE, sing: 0, sat: 0}});
      // Most negative diagonal: the determinant clips, the inverse is -2 raw.
      table_rows.push_back('{m: '{MINV, z, z, z, MINV, z, z, z, MINV}, fixed: 1,
                             want: '{inv: '{-2, z, z, z, -2, z, z, z, -2},
                                     det: MINV, sing: 0, sat: 1}});
      // Determinant just at and just above the reset threshold, and below it.
      table_rows.push_back('{m: '{ONE, z, z, z, ONE, z, z, z, 7}, fixed: 0, want: zero_inv});
      table_rows.push_back('{m: '{ONE, z, z, z, ONE, z, z, z, 8}, fixed: 0, want: zero_inv});
      table_rows.push_back('{m: '{ONE, z, z, z, ONE, z, z, z, -8}, fixed: 0, want: zero_inv});
      table_rows.push_back('{m: '{ONE, z, z, z, ONE, z, z, z, 1}, fixed: 0, want: zero_inv});
      table_rows.push_back('{m: '{MAXV, z, z, z, MAXV, z, z, z, MAXV}, fixed: 0,
                             want: zero_inv});
      table_rows.push_back('{m: '{z, ONE, z, z, z, ONE, ONE, z, z}, fixed: 0, want: zero_inv});
      table_rows.push_back('{m: '{3 * ONE, -ONE, 5, 7 * ONE, 2 * ONE, -3, MINV, 9, ONE},
                             fixed: 0, want: zero_inv});
      table_rows.push_back('{m: '{-1, -1, 1, 1, -1, -1, -1, 1, -1}, fixed: 0, want: zero_inv});

      foreach (table_rows[r]) send_matrix(table_rows[r].m, table_rows[r].fixed,
                                          table_rows[r].want);
      req_bus.valid <= 1'b0;
      // The sender holds off here until every inverse has come back.
      wait_idle();

      send_random(250);
      wait_idle();
      // Zero threshold: only an exact zero determinant is singular, tiny ones saturate.
      write_threshold('0);
      send_random(200);
      wait_idle();
      write_threshold({mi3_pkg::THR_W{1'b1}});
      send_random(200);
      wait_idle();
      write_threshold(thr_type'($urandom_range(0, 1 << 20)));
      send_random(150);
      wait_idle();
      write_threshold(mi3_pkg::THR_RESET);
      send_random(150);
      wait_idle();

      if (error_count == 0 && pending_inverses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
